// File: sv/bwsd_pkg.sv
// ----------------------------------------------------------------------------
// Band weighted spectrum package
// Shared types, register indexes, level constants and the twiddle function.
// ----------------------------------------------------------------------------
package bwsd_pkg;

  localparam int REG_DEEP_BASS_GAIN = 0;
  localparam int REG_BASS_GAIN      = 1;
  localparam int REG_TREBLE_GAIN    = 2;
  localparam int REG_NORMAL_GAIN    = 3;
  localparam int REG_FULL_SCALE     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;
  localparam int LOG_W      = 22;

  localparam logic [15:0] LEVEL_MIN   = 16'h8000;
  localparam logic [15:0] LEVEL_MAX   = 16'h7FFF;
  localparam int          DB_PER_LOG2 = 197283;
  localparam int          LOG_OFFSET  = 26 * 65536;

  localparam longint CORDIC_START = 9949;
  localparam longint TW_ONE       = 16384;
  localparam longint CORDIC_ANGLE [16] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] result;
  } log_rsp_t;

  // Cosine and sine of a phase in 1/65536 turn, Q1.14, packed as {cos, sin}.
  function automatic logic [31:0] twiddle(input int unsigned p);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    logic [1:0] quad;
    quad = 2'((p >> 14) & 3);
    z = longint'(p & 32'h3FFF);
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - CORDIC_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + CORDIC_ANGLE[i];
      end
    end
    if (x > TW_ONE) x = TW_ONE;
    if (x < -TW_ONE) x = -TW_ONE;
    if (y > TW_ONE) y = TW_ONE;
    if (y < -TW_ONE) y = -TW_ONE;
    case (quad)
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    return {c[15:0], s[15:0]};
  endfunction

endpackage

// File: sv/bwsd_if.sv
// ----------------------------------------------------------------------------
// Band weighted spectrum stream interfaces
// Sample input channel and per-bin result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bwsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bwsd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [15:0] level_db;
  logic        last_bin;

  modport source (output valid, output bin_index, output level_db, output last_bin,
                  input ready);
  modport sink (input valid, input bin_index, input level_db, input last_bin,
                output ready);
endinterface

// File: sv/bwsd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bwsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bwsd_log2.sv
// ----------------------------------------------------------------------------
// Iterative log2 unit
// Normalizes in six shift steps, then squares sixteen times for 16 fraction
// bits. The result is registered and flagged by a one-cycle done bit.
// ----------------------------------------------------------------------------
module bwsd_log2 (
  input  logic               clk,
  input  logic               rst_n,
  input  bwsd_pkg::log_req_t req,
  output bwsd_pkg::log_rsp_t rsp
);

  localparam logic [1:0] L_IDLE  = 2'd0;
  localparam logic [1:0] L_NORM  = 2'd1;
  localparam logic [1:0] L_LOADM = 2'd2;
  localparam logic [1:0] L_SQ    = 2'd3;

  logic [1:0]  st_r;
  logic        done_r;
  logic [63:0] x_r;
  logic [5:0]  e_r;
  logic [3:0]  cnt_r;
  logic [31:0] m_r;
  logic [15:0] frac_r;

  logic [5:0]  sh;
  logic [63:0] top_mask;
  logic [63:0] prod;
  logic [32:0] sq;

  always_comb begin
    case (cnt_r)
      4'd0:    sh = 6'd32;
      4'd1:    sh = 6'd16;
      4'd2:    sh = 6'd8;
      4'd3:    sh = 6'd4;
      4'd4:    sh = 6'd2;
      default: sh = 6'd1;
    endcase
    top_mask = ~({64{1'b1}} >> sh);
    prod     = 64'(m_r) * 64'(m_r);
    sq       = prod[63:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (req.start) begin
            x_r   <= req.value;
            e_r   <= 6'd63;
            cnt_r <= 4'd0;
            st_r  <= L_NORM;
          end
        end
        L_NORM: begin
          if ((x_r & top_mask) == 64'd0) begin
            x_r <= x_r << sh;
            e_r <= e_r - sh;
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd5) begin
            st_r <= L_LOADM;
          end
        end
        L_LOADM: begin
          m_r    <= x_r[63:32];
          frac_r <= 16'd0;
          cnt_r  <= 4'd0;
          st_r   <= L_SQ;
        end
        L_SQ: begin
          if (sq[32]) begin
            m_r    <= sq[32:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            m_r    <= sq[31:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            st_r   <= L_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = {e_r, frac_r};

endmodule

// File: sv/band_weighted_spectrum_db_unit.sv
// ----------------------------------------------------------------------------
// Band weighted spectrum analyzer, level in dB per bin
// Samples: one per cycle while a frame fills. The frame's last sample starts
// the transform, FRAME_POINTS/2 bins of FRAME_POINTS samples each at one
// multiply pair per cycle through the sample memory read port, then a pipeline drain.
// Each bin then takes three passes of the shared log2 unit and waits until
// its word is taken; a bin with zero magnitude or zero gain skips the log2 unit.
// Reset clears the sample count and the control state and sets the gain and full
// scale registers to their defaults; the sample and work memories are not cleared.
// ----------------------------------------------------------------------------
module band_weighted_spectrum_db_unit #(
  parameter int FRAME_POINTS = 128,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bwsd_in_if.sink                       in_ch,
  bwsd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  bwsd_pkg::cfg_idx_t            cfg_index,
  input  logic [bwsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF    = FRAME_POINTS / 2;
  localparam int AW      = $clog2(FRAME_POINTS);
  localparam int KW      = $clog2(HALF);
  localparam int PROD_W  = SAMPLE_BITS + 16;
  localparam int ACC_W   = PROD_W + AW;
  localparam int RND_W   = ACC_W - 13;
  localparam int ABS_W   = SAMPLE_BITS + AW + 1;
  localparam int SUM_W   = (2 * ABS_W + 1 > 64) ? 64 : 2 * ABS_W + 1;
  localparam int DEEP_HI = HALF / 8;
  localparam int BASS_HI = HALF / 4;
  localparam int TREB_LO = 3 * HALF / 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DFT   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_LOG   = 3'd5;
  localparam logic [2:0] S_CALC  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r;

  logic [15:0] deep_gain_r;
  logic [15:0] bass_gain_r;
  logic [15:0] treb_gain_r;
  logic [15:0] norm_gain_r;
  logic [31:0] fs_r;

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] n_r;
  logic [AW-1:0] m_r;
  logic [KW-1:0] k_r;
  logic [AW:0]   msum;

  logic [31:0] tw_rom [FRAME_POINTS];

  for (genvar gi = 0; gi < FRAME_POINTS; gi++) begin : g_tw
    localparam int unsigned PH = ((gi * 65536 + FRAME_POINTS / 2) / FRAME_POINTS) % 65536;
    assign tw_rom[gi] = bwsd_pkg::twiddle(PH);
  end

  logic [23:0]            smp_ext;
  logic [SAMPLE_BITS-1:0] smp_raw;
  logic [SAMPLE_BITS-1:0] smp_rd;
  logic                   in_acc;

  assign smp_ext = {8'd0, in_ch.sample};
  assign smp_raw = smp_ext[SAMPLE_BITS-1:0];
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  bwsd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_POINTS)) u_smp_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cnt_r),
    .wdata (smp_raw),
    .raddr (n_r),
    .rdata (smp_rd)
  );

  // Transform pipeline.
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                     first1_r, first2_r, last1_r, last2_r;
  logic [KW-1:0]            k1_r, k2_r, k3_r, k4_r, k5_r;
  logic signed [15:0]       c1_r, s1_r;
  logic signed [PROD_W-1:0] pre_r, pim_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0]  rnd_re, rnd_im;
  logic signed [RND_W-1:0]  rr, ii;
  logic [ABS_W-1:0]         ar_r, ai_r;
  logic [2*ABS_W-1:0]       sqr_r, sqi_r;
  logic [2*ABS_W:0]         sq_sum;
  logic [SUM_W-1:0]         work_rd;

  assign rnd_re = acc_re_r + ACC_W'(4096);
  assign rnd_im = acc_im_r + ACC_W'(4096);
  assign rr     = rnd_re[ACC_W-1:13];
  assign ii     = rnd_im[ACC_W-1:13];
  assign sq_sum = {1'b0, sqr_r} + {1'b0, sqi_r};
  assign msum   = {1'b0, m_r} + (AW + 1)'(k_r);

  bwsd_ram #(.WIDTH(SUM_W), .DEPTH(HALF)) u_work_ram (
    .clk   (clk),
    .we    (v5_r),
    .waddr (k5_r),
    .wdata (SUM_W'(sq_sum)),
    .raddr (k_r),
    .rdata (work_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_DFT);
      v2_r <= v1_r;
      v3_r <= v2_r && last2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (n_r == '0);
    last1_r  <= (n_r == AW'(FRAME_POINTS - 1));
    k1_r     <= k_r;
    c1_r     <= tw_rom[m_r][31:16];
    s1_r     <= tw_rom[m_r][15:0];
    first2_r <= first1_r;
    last2_r  <= last1_r;
    k2_r     <= k1_r;
    pre_r    <= $signed(smp_rd) * c1_r;
    pim_r    <= $signed(smp_rd) * s1_r;
    if (v2_r) begin
      acc_re_r <= (first2_r ? ACC_W'(0) : acc_re_r) + ACC_W'(pre_r);
      acc_im_r <= (first2_r ? ACC_W'(0) : acc_im_r) - ACC_W'(pim_r);
    end
    k3_r  <= k2_r;
    ar_r  <= ABS_W'(rr[RND_W-1] ? -rr : rr);
    ai_r  <= ABS_W'(ii[RND_W-1] ? -ii : ii);
    k4_r  <= k3_r;
    sqr_r <= ar_r * ar_r;
    sqi_r <= ai_r * ai_r;
    k5_r  <= k4_r;
  end

  // Level computation.
  bwsd_pkg::log_req_t log_req;
  bwsd_pkg::log_rsp_t log_rsp;

  bwsd_log2 u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (log_req),
    .rsp   (log_rsp)
  );

  logic [15:0]                   gain_sel;
  logic [15:0]                   gain_r;
  logic [31:0]                   fs_eff;
  logic [1:0]                    lsel_r;
  logic [1:0]                    csub_r;
  logic [bwsd_pkg::LOG_W-1:0]    ls_r, lg_r, lf_r;
  logic signed [25:0]            t_r;
  logic signed [44:0]            mul_r;
  logic signed [44:0]            mul_rnd;
  logic signed [20:0]            db_sh;
  logic [15:0]                   db_r;

  always_comb begin
    if (k_r < KW'(DEEP_HI)) begin
      gain_sel = deep_gain_r;
    end else if (k_r > KW'(DEEP_HI) && k_r < KW'(BASS_HI)) begin
      gain_sel = bass_gain_r;
    end else if (k_r > KW'(TREB_LO)) begin
      gain_sel = treb_gain_r;
    end else begin
      gain_sel = norm_gain_r;
    end
  end

  assign fs_eff  = (fs_r == 32'd0) ? 32'd1 : fs_r;
  assign mul_rnd = mul_r + 45'sd8388608;
  assign db_sh   = mul_rnd[44:24];

  always_comb begin
    log_req.start = 1'b0;
    log_req.value = 64'(work_rd);
    if (state_r == S_LOAD) begin
      log_req.start = (work_rd != '0) && (gain_sel != 16'd0);
    end else if (state_r == S_LOG && log_rsp.done && lsel_r != 2'd2) begin
      log_req.start = 1'b1;
      log_req.value = (lsel_r == 2'd0) ? 64'(gain_r) : 64'(fs_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      deep_gain_r <= 16'd4096;
      bass_gain_r <= 16'd4096;
      treb_gain_r <= 16'd4096;
      norm_gain_r <= 16'd4096;
      fs_r        <= 32'd4194304;
    end else begin
      if (cfg_we) begin
        case (int'(cfg_index))
          bwsd_pkg::REG_DEEP_BASS_GAIN: deep_gain_r <= cfg_data[15:0];
          bwsd_pkg::REG_BASS_GAIN:      bass_gain_r <= cfg_data[15:0];
          bwsd_pkg::REG_TREBLE_GAIN:    treb_gain_r <= cfg_data[15:0];
          bwsd_pkg::REG_NORMAL_GAIN:    norm_gain_r <= cfg_data[15:0];
          bwsd_pkg::REG_FULL_SCALE:     fs_r        <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (cnt_r == AW'(FRAME_POINTS - 1)) begin
              cnt_r   <= '0;
              n_r     <= '0;
              m_r     <= '0;
              k_r     <= '0;
              state_r <= S_DFT;
            end else begin
              cnt_r <= cnt_r + AW'(1);
            end
          end
        end
        S_DFT: begin
          if (msum >= (AW + 1)'(FRAME_POINTS)) begin
            m_r <= AW'(msum - (AW + 1)'(FRAME_POINTS));
          end else begin
            m_r <= AW'(msum);
          end
          n_r <= n_r + AW'(1);
          if (n_r == AW'(FRAME_POINTS - 1)) begin
            n_r <= '0;
            m_r <= '0;
            if (k_r == KW'(HALF - 1)) begin
              state_r <= S_DRAIN;
            end else begin
              k_r <= k_r + KW'(1);
            end
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r && !v4_r && !v5_r) begin
            k_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          gain_r <= gain_sel;
          lsel_r <= 2'd0;
          if (work_rd == '0 || gain_sel == 16'd0) begin
            db_r    <= bwsd_pkg::LEVEL_MIN;
            state_r <= S_OUT;
          end else begin
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_rsp.done) begin
            case (lsel_r)
              2'd0:    ls_r <= log_rsp.result;
              2'd1:    lg_r <= log_rsp.result;
              default: lf_r <= log_rsp.result;
            endcase
            if (lsel_r == 2'd2) begin
              csub_r  <= 2'd0;
              state_r <= S_CALC;
            end else begin
              lsel_r <= lsel_r + 2'd1;
            end
          end
        end
        S_CALC: begin
          csub_r <= csub_r + 2'd1;
          if (csub_r == 2'd0) begin
            t_r <= $signed(26'(ls_r) + 26'({lg_r, 1'b0}) - 26'({lf_r, 1'b0})
                   - 26'(bwsd_pkg::LOG_OFFSET));
          end else if (csub_r == 2'd1) begin
            mul_r <= t_r * $signed(19'(bwsd_pkg::DB_PER_LOG2));
          end else begin
            if (db_sh < -21'sd32768) begin
              db_r <= bwsd_pkg::LEVEL_MIN;
            end else if (db_sh > 21'sd32767) begin
              db_r <= bwsd_pkg::LEVEL_MAX;
            end else begin
              db_r <= db_sh[15:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (k_r == KW'(HALF - 1)) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + KW'(1);
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.bin_index = 6'(k_r);
  assign out_ch.level_db  = db_r;
  assign out_ch.last_bin  = (k_r == KW'(HALF - 1));

endmodule

// File: sv/bwsd_checker.sv
// ----------------------------------------------------------------------------
// Band weighted spectrum port checker
// Watches the top level's ports for ordering of samples and bin words.
// ----------------------------------------------------------------------------
module bwsd_checker #(
  parameter int FRAME_POINTS = 128
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_bin_index,
  input logic       out_last_bin
);

  localparam int HALF = FRAME_POINTS / 2;

  a_no_sample_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Sample port ready while a bin word is pending.");

  a_last_is_top_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_bin) |-> (out_bin_index == 6'(HALF - 1)))
    else $error("Last bin flag on a wrong bin.");

  a_ready_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_bin) |=> in_ready)
    else $error("Sample port not ready after the final bin.");

  a_gap_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("Bin word repeated in the next cycle.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Bin word valid after reset.");

endmodule

bind band_weighted_spectrum_db_unit bwsd_checker #(.FRAME_POINTS(FRAME_POINTS)) u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bin_index (out_ch.bin_index),
  .out_last_bin  (out_ch.last_bin)
);

// File: dv/band_weighted_spectrum_db_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band weighted spectrum analyzer testbench
// Streams frames of samples through the analyzer with random idling on both
// channels and checks every per-bin dB word against a built-in fixed-point
// model of the transform, band gains and log stage, across gain settings.
// ----------------------------------------------------------------------------
module band_weighted_spectrum_db_unit_tb;

  localparam int POINTS     = 128;
  localparam int BINS       = POINTS / 2;
  localparam int CFG_UNUSED = 5;
  localparam int CFG_TOP    = 7;
  localparam int LIMIT      = 3000000;

  typedef struct {
    logic [5:0]  bin;
    logic [15:0] level;
    logic        last;
  } bin_word_t;

  typedef struct {
    logic        is_cfg;
    int          idx;
    logic [31:0] val;
    int          reps;
    logic        all_floor;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  bwsd_pkg::cfg_idx_t cfg_index;
  logic [bwsd_pkg::CFG_DATA_W-1:0] cfg_data;

  bwsd_in_if in_ch ();
  bwsd_out_if out_ch ();

  band_weighted_spectrum_db_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bin_word_t levels_due[$];
  longint cos_q14 [POINTS];
  longint sin_q14 [POINTS];
  longint frame_buf [POINTS];
  logic [63:0] power_of_bin [BINS];
  int fill_count;
  logic [15:0] gain_deep, gain_bass, gain_treble, gain_normal;
  logic [31:0] full_scale;
  int errors;
  int cycles;
  bit calm;

  row_t rows [16] = '{
    '{0, 0, 32'd0, 128, 1},
    '{1, bwsd_pkg::REG_DEEP_BASS_GAIN, 32'd65535, 0, 0},
    '{1, bwsd_pkg::REG_BASS_GAIN, 32'd0, 0, 0},
    '{1, bwsd_pkg::REG_TREBLE_GAIN, 32'd65535, 0, 0},
    '{1, bwsd_pkg::REG_NORMAL_GAIN, 32'd1, 0, 0},
    '{1, bwsd_pkg::REG_FULL_SCALE, 32'd1, 0, 0},
    '{1, CFG_UNUSED, 32'd123, 0, 0},
    '{1, CFG_TOP, 32'd0, 0, 0},
    '{0, 0, 32'h7FFF, 8, 0},
    '{0, 0, 32'h8000, 8, 0},
    '{0, 0, 32'h5555, 8, 0},
    '{0, 0, 32'hAAAA, 8, 0},
    '{0, 0, 32'hFFFF, 16, 0},
    '{0, 0, 32'h0001, 16, 0},
    '{0, 0, 32'h7FFF, 32, 0},
    '{0, 0, 32'h8000, 32, 0}
  };

  function automatic void build_twiddles();
    longint x, y, z, dx, dy;
    longint angle [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                           3, 1, 1, 0};
    int unsigned p;
    for (int m = 0; m < POINTS; m++) begin
      p = ((m * 65536 + POINTS / 2) / POINTS) & 16'hFFFF;
      z = p & 16'h3FFF;
      x = 9949;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= angle[i];
        end else begin
          x += dx; y -= dy; z += angle[i];
        end
      end
      if (x > 16384) x = 16384;
      if (x < -16384) x = -16384;
      if (y > 16384) y = 16384;
      if (y < -16384) y = -16384;
      case ((p >> 14) & 3)
        0: begin cos_q14[m] = x;  sin_q14[m] = y;  end
        1: begin cos_q14[m] = -y; sin_q14[m] = x;  end
        2: begin cos_q14[m] = -x; sin_q14[m] = -y; end
        default: begin cos_q14[m] = y; sin_q14[m] = -x; end
      endcase
    end
  endfunction

  function automatic longint log2_fix(logic [63:0] v);
    int e;
    logic [63:0] m;
    longint frac;
    frac = 0;
    e = 63;
    while (e > 0 && !v[e]) e--;
    m = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int b = 0; b < 16; b++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic logic [15:0] weighted_db(int k);
    logic [15:0] g;
    logic [31:0] fs;
    longint t, db;
    if (k < BINS / 8) g = gain_deep;
    else if (k > BINS / 8 && k < BINS / 4) g = gain_bass;
    else if (k > 3 * BINS / 4) g = gain_treble;
    else g = gain_normal;
    fs = (full_scale == 0) ? 32'd1 : full_scale;
    if (power_of_bin[k] == 0 || g == 0) return bwsd_pkg::LEVEL_MIN;
    t = log2_fix(power_of_bin[k]) + 2 * log2_fix(64'(g)) - 2 * log2_fix(64'(fs))
        - 26 * 65536;
    db = (t * 197283 + (longint'(1) << 23)) >>> 24;
    if (db < -32768) return bwsd_pkg::LEVEL_MIN;
    if (db > 32767) return bwsd_pkg::LEVEL_MAX;
    return db[15:0];
  endfunction

  function automatic void absorb_sample(logic [15:0] s, bit all_floor);
    longint re, im, rr, ii;
    frame_buf[fill_count] = longint'($signed(s));
    fill_count++;
    if (fill_count < POINTS) return;
    fill_count = 0;
    for (int k = 0; k < BINS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < POINTS; n++) begin
        re += frame_buf[n] * cos_q14[(k * n) % POINTS];
        im -= frame_buf[n] * sin_q14[(k * n) % POINTS];
      end
      rr = (re + 4096) >>> 13;
      ii = (im + 4096) >>> 13;
      if (rr < 0) rr = -rr;
      if (ii < 0) ii = -ii;
      power_of_bin[k] = rr * rr + ii * ii;
      levels_due.push_back('{6'(k), all_floor ? bwsd_pkg::LEVEL_MIN : weighted_db(k),
                             k == BINS - 1});
    end
  endfunction

  task automatic send_sample(logic [15:0] s, bit all_floor);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    absorb_sample(s, all_floor);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= bwsd_pkg::cfg_idx_t'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bwsd_pkg::REG_DEEP_BASS_GAIN: gain_deep = val[15:0];
      bwsd_pkg::REG_BASS_GAIN: gain_bass = val[15:0];
      bwsd_pkg::REG_TREBLE_GAIN: gain_treble = val[15:0];
      bwsd_pkg::REG_NORMAL_GAIN: gain_normal = val[15:0];
      bwsd_pkg::REG_FULL_SCALE: full_scale = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd4096;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($signed(10'($urandom)));
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[band_weighted_spectrum_db_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    bin_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (levels_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: bin %0d level %h last %b",
                                     out_ch.bin_index, out_ch.level_db, out_ch.last_bin);
        end else begin
          want = levels_due.pop_front();
          if (out_ch.bin_index !== want.bin || out_ch.level_db !== want.level ||
              out_ch.last_bin !== want.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp bin %0d level %h last %b, got %0d %h %b",
                                       want.bin, want.level, want.last, out_ch.bin_index,
                                       out_ch.level_db, out_ch.last_bin);
          end
        end
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  initial begin
    clk = 1'b0;
    cycles = 0;
    errors = 0;
    calm = 0;
    fill_count = 0;
    gain_deep = 16'd4096;
    gain_bass = 16'd4096;
    gain_treble = 16'd4096;
    gain_normal = 16'd4096;
    full_scale = 32'd4194304;
    build_twiddles();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        drain();
        write_reg(rows[r].idx, rows[r].val);
      end else begin
        for (int j = 0; j < rows[r].reps; j++) send_sample(rows[r].val[15:0],
                                                           rows[r].all_floor);
      end
    end

    drain();
    write_reg(bwsd_pkg::REG_DEEP_BASS_GAIN, 32'(pick_gain()));
    write_reg(bwsd_pkg::REG_BASS_GAIN, 32'(pick_gain()));
    write_reg(bwsd_pkg::REG_TREBLE_GAIN, 32'(pick_gain()));
    write_reg(bwsd_pkg::REG_NORMAL_GAIN, 32'(pick_gain()));
    write_reg(bwsd_pkg::REG_FULL_SCALE, $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF);
    calm = 1;
    for (int j = 0; j < POINTS; j++) send_sample(random_sample(), 0);
    drain();
    calm = 0;
    write_reg(bwsd_pkg::REG_FULL_SCALE, 32'(1 + $urandom_range(65535)));
    for (int j = 0; j < 54; j++) send_sample(random_sample(), 0);

    drain();
    if (errors == 0) begin
      $display("[band_weighted_spectrum_db_unit] OK");
    end else begin
      $display("[band_weighted_spectrum_db_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: band_weighted_spectrum_db_unit.f
sv/bwsd_pkg.sv
sv/bwsd_if.sv
sv/bwsd_ram.sv
sv/bwsd_log2.sv
sv/band_weighted_spectrum_db_unit.sv
sv/bwsd_checker.sv
dv/band_weighted_spectrum_db_unit_tb.sv
